// ===== design/slab_pkg.sv =====
package slab_pkg;

  localparam int MaxSlabsDef    = 16;
  localparam int MaxEntriesDef  = 256;
  localparam int HeaderBytesDef = 20;
  localparam int LinkBytesDef   = 4;

  localparam int ModeW  = 2;
  localparam int StatW  = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 13;

  localparam logic [ModeW-1:0] MODE_ALLOC = 2'd0;
  localparam logic [ModeW-1:0] MODE_FREE  = 2'd1;
  localparam logic [ModeW-1:0] MODE_REAP  = 2'd2;

  localparam logic [StatW-1:0] ST_OK      = 2'd0;
  localparam logic [StatW-1:0] ST_NOFRAME = 2'd1;
  localparam logic [StatW-1:0] ST_NOREAP  = 2'd2;
  localparam logic [StatW-1:0] ST_IDLEFREE = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_SLAB_LOG2 = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ELEM_SIZE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ALIGN_LOG2 = 2'd2;

endpackage

// ===== design/slab_allocator_core.sv =====
// Slab allocator core. Each request (allocate, free, reap) returns exactly one
// result. The shift-subtract divider first recomputes the slab capacity from
// the current registers; when it finishes, a new slab is built if an allocate
// needs one. Then the free-link memory is read, and last the slab state is
// updated and the result registered. The input stays stalled from acceptance
// until the result register is taken, so a new request is accepted only once
// the previous result is taken. A pending configuration write also stalls the
// input, and the registers are written only between requests.
module slab_allocator_core import slab_pkg::*; #(
  parameter int MAX_SLABS    = MaxSlabsDef,
  parameter int MAX_ENTRIES  = MaxEntriesDef,
  parameter int HEADER_BYTES = HeaderBytesDef,
  parameter int LINK_BYTES   = LinkBytesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDatW-1:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [3:0]  free_slab,
  input  logic [7:0]  free_entry,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  slab_index,
  output logic [7:0]  entry_index,
  output logic [15:0] byte_offset,
  output logic [16:0] reclaimed_bytes
);
  localparam int SW = $clog2(MAX_SLABS+1);
  localparam int SI = $clog2(MAX_SLABS);
  localparam int EW = $clog2(MAX_ENTRIES+1);
  localparam int EI = $clog2(MAX_ENTRIES);
  localparam logic [SW-1:0] NIL_S = SW'(MAX_SLABS);
  localparam logic [EW-1:0] NIL_E = EW'(MAX_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_GEOM = 4'b0010, S_LINK = 4'b0100, S_EXEC = 4'b1000
  } state_t;

  state_t state;
  logic [4:0]  r_slog;
  logic [12:0] r_esz;
  logic [2:0]  r_alog;

  logic [1:0]  q_mode;
  logic [SI-1:0] q_slab;
  logic [EI-1:0] q_entry;
  logic        q_slab_ok, q_entry_ok;

  logic [EW-1:0] freed_top [MAX_SLABS];
  logic [EW-1:0] untouched [MAX_SLABS];
  logic [EW-1:0] used      [MAX_SLABS];
  logic [15:0]   color     [MAX_SLABS];
  logic [SW-1:0] lprev     [MAX_SLABS];
  logic [SW-1:0] lnext     [MAX_SLABS];
  logic [SW-1:0] head, avail, tail;
  logic [15:0]   next_color;
  logic [MAX_SLABS-1:0] fmap;

  logic [EW-1:0] link_mem [MAX_SLABS*MAX_ENTRIES];
  logic [EW-1:0] link_rd;
  logic [SI+EI-1:0] link_raddr;

  logic geo_start, geo_done;
  logic [16:0] sbytes, gfirst, gesize;
  logic [EW-1:0] gcap;

  slab_geom #(.MAX_ENTRIES(MAX_ENTRIES), .HEADER_BYTES(HEADER_BYTES),
              .LINK_BYTES(LINK_BYTES)) u_geom (
    .clk, .rst, .slab_size_log2(r_slog), .element_size(r_esz),
    .alignment_log2(r_alog), .start(geo_start), .done(geo_done),
    .slab_bytes(sbytes), .first(gfirst), .esize(gesize), .cap(gcap)
  );

  assign cfg_ready = (state == S_IDLE);
  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall) || cfg_valid;
  assign geo_start = (state == S_IDLE) && in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      r_slog <= 5'd12;
      r_esz  <= 13'd32;
      r_alog <= 3'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SLAB_LOG2:  r_slog <= cfg_data[4:0];
        REG_ELEM_SIZE:  r_esz  <= cfg_data;
        REG_ALIGN_LOG2: r_alog <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Free-link memory: read the head-of-list link of the avail slab, write on free
  assign link_raddr = {avail[SI-1:0], freed_top[avail[SI-1:0]][EI-1:0]};
  always_ff @(posedge clk) begin
    link_rd <= link_mem[link_raddr];
    if (state == S_EXEC && q_mode == MODE_FREE && q_slab_ok && q_entry_ok &&
        !fmap[q_slab] && used[q_slab] != '0)
      link_mem[{q_slab, q_entry}] <= freed_top[q_slab];
  end

  // Request execution: new slab built at geometry done, other updates in S_EXEC
  always_ff @(posedge clk) begin
    logic [SW-1:0] f, s, n, p, av, hd, tl;
    logic [EW-1:0] e;
    logic [EW-1:0] ft_s, ut_s, us_s;
    logic [16:0] nc;
    logic [31:0] tot;
    logic ok, wasfull;
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_SLABS; i++) begin
        freed_top[i] <= NIL_E;
        untouched[i] <= '0;
        used[i] <= '0;
        color[i] <= '0;
        lprev[i] <= NIL_S;
        lnext[i] <= NIL_S;
      end
      head <= NIL_S; avail <= NIL_S; tail <= NIL_S;
      next_color <= '0;
      fmap <= '1;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (geo_start) begin
          q_mode <= mode;
          q_slab <= SI'(free_slab);
          q_entry <= EI'(free_entry);
          q_slab_ok <= (32'(free_slab) < MAX_SLABS);
          q_entry_ok <= (32'(free_entry) < MAX_ENTRIES);
          state <= S_GEOM;
        end
        S_GEOM: if (geo_done) begin
          // Build a new slab first if allocating with no available slab
          if (q_mode == MODE_ALLOC && avail == NIL_S && gcap != '0 && fmap != '0) begin
            f = NIL_S;
            for (int i = MAX_SLABS-1; i >= 0; i--) if (fmap[i]) f = SW'(i);
            fmap[f[SI-1:0]] <= 1'b0;
            freed_top[f[SI-1:0]] <= NIL_E;
            untouched[f[SI-1:0]] <= gcap;
            used[f[SI-1:0]] <= '0;
            color[f[SI-1:0]] <= next_color;
            nc = 17'(next_color) + (17'd1 << r_alog);
            tot = 32'(gfirst) + 32'(nc) + 32'(gesize) * 32'(gcap);
            next_color <= (tot > 32'(sbytes)) ? 16'd0 : nc[15:0];
            lnext[f[SI-1:0]] <= NIL_S;
            avail <= f;
            if (tail != NIL_S) begin
              lnext[tail[SI-1:0]] <= f;
              lprev[f[SI-1:0]] <= tail;
            end else begin
              lprev[f[SI-1:0]] <= NIL_S;
              head <= f;
            end
            tail <= f;
          end
          state <= S_LINK;
        end
        S_LINK: state <= S_EXEC;
        S_EXEC: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
          status <= ST_OK;
          slab_index <= '0;
          entry_index <= '0;
          byte_offset <= '0;
          reclaimed_bytes <= '0;
          case (q_mode)
            MODE_ALLOC: begin
              if (avail == NIL_S) status <= ST_NOFRAME;
              else begin
                s = avail;
                ft_s = freed_top[s[SI-1:0]];
                ut_s = untouched[s[SI-1:0]];
                ok = 1'b1;
                if (ft_s != NIL_E) begin
                  e = ft_s;
                  ft_s = link_rd;
                end else if (ut_s != '0) begin
                  ut_s = ut_s - 1'b1;
                  e = ut_s;
                end else begin
                  ok = 1'b0;
                  e = '0;
                end
                if (!ok) status <= ST_NOFRAME;
                else begin
                  freed_top[s[SI-1:0]] <= ft_s;
                  untouched[s[SI-1:0]] <= ut_s;
                  used[s[SI-1:0]] <= used[s[SI-1:0]] + 1'b1;
                  if (ft_s == NIL_E && ut_s == '0) avail <= lnext[s[SI-1:0]];
                  tot = 32'(gfirst) + 32'(color[s[SI-1:0]]) + 32'(e) * 32'(gesize)
                        + 32'(LINK_BYTES);
                  slab_index <= 4'(s);
                  entry_index <= 8'(e);
                  byte_offset <= tot[15:0];
                end
              end
            end
            MODE_FREE: begin
              if (!q_slab_ok || !q_entry_ok || fmap[q_slab] || used[q_slab] == '0)
                status <= ST_IDLEFREE;
              else begin
                s = SW'(q_slab);
                wasfull = freed_top[q_slab] == NIL_E && untouched[q_slab] == '0;
                us_s = used[q_slab] - 1'b1;
                freed_top[q_slab] <= EW'(q_entry);
                used[q_slab] <= us_s;
                n = lnext[q_slab];
                av = avail; hd = head; tl = tail;
                if (wasfull) begin
                  if (n != NIL_S && freed_top[n[SI-1:0]] == NIL_E &&
                      untouched[n[SI-1:0]] == '0) begin
                    // move s right before avail (or to tail)
                    p = lprev[q_slab];
                    if (s == hd) hd = n;
                    if (p != NIL_S) lnext[p[SI-1:0]] <= n;
                    lprev[n[SI-1:0]] <= p;
                    if (av != NIL_S) begin
                      p = lprev[av[SI-1:0]];
                      if (p == s) p = lprev[q_slab];
                      if (p != NIL_S) begin
                        lnext[p[SI-1:0]] <= s;
                        lprev[q_slab] <= p;
                      end else begin
                        lprev[q_slab] <= NIL_S;
                        hd = s;
                      end
                      lnext[q_slab] <= av;
                      lprev[av[SI-1:0]] <= s;
                    end else begin
                      if (tl == s) tl = lprev[q_slab];
                      lnext[tl[SI-1:0]] <= s;
                      if (tl == n) lnext[n[SI-1:0]] <= s;
                      lprev[q_slab] <= tl;
                      lnext[q_slab] <= NIL_S;
                      tl = s;
                    end
                  end
                  av = s;
                end else if (us_s == '0) begin
                  if (n != NIL_S && used[n[SI-1:0]] != '0) begin
                    p = lprev[q_slab];
                    if (s == hd) hd = n;
                    if (s == av) av = n;
                    if (p != NIL_S) lnext[p[SI-1:0]] <= n;
                    lprev[n[SI-1:0]] <= p;
                    if (tl == n) lnext[n[SI-1:0]] <= s;
                    else lnext[tl[SI-1:0]] <= s;
                    lprev[q_slab] <= tl;
                    lnext[q_slab] <= NIL_S;
                    tl = s;
                  end
                end
                avail <= av; head <= hd; tail <= tl;
              end
            end
            MODE_REAP: begin
              s = tail;
              if (head == NIL_S || s == NIL_S || s == head || used[s[SI-1:0]] != '0)
                status <= ST_NOREAP;
              else begin
                p = lprev[s[SI-1:0]];
                if (avail == s) avail <= NIL_S;
                tail <= p;
                lnext[p[SI-1:0]] <= NIL_S;
                lprev[s[SI-1:0]] <= NIL_S;
                lnext[s[SI-1:0]] <= NIL_S;
                freed_top[s[SI-1:0]] <= NIL_E;
                untouched[s[SI-1:0]] <= '0;
                color[s[SI-1:0]] <= '0;
                fmap[s[SI-1:0]] <= 1'b1;
                reclaimed_bytes <= sbytes;
              end
            end
            default: ;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> out_valid) else $error("missing result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("accept while busy");
  a_geom_done: assert property (@(posedge clk) disable iff (rst)
    geo_done |-> state == S_GEOM) else $error("stray geometry done");

endmodule

// ===== design/slab_geom.sv =====
// Slab geometry: slab size, entry size, first offset and capacity.
// Capacity is found by a shift-subtract divider, one quotient bit a cycle.
module slab_geom import slab_pkg::*; #(
  parameter int MAX_ENTRIES  = MaxEntriesDef,
  parameter int HEADER_BYTES = HeaderBytesDef,
  parameter int LINK_BYTES   = LinkBytesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  slab_size_log2,
  input  logic [12:0] element_size,
  input  logic [2:0]  alignment_log2,
  input  logic        start,
  output logic        done,
  output logic [16:0] slab_bytes,
  output logic [16:0] first,
  output logic [16:0] esize,
  output logic [$clog2(MAX_ENTRIES+1)-1:0] cap
);
  localparam int CapW = $clog2(MAX_ENTRIES+1);
  localparam int QW = 17;

  logic [4:0]  lg;
  logic [7:0]  align;
  logic [16:0] hdr;
  logic        busy;
  logic [4:0]  cnt;
  logic [16:0] rem;
  logic [16:0] num;
  logic [16:0] quo;
  logic [17:0] trial;

  // Saturate slab size and round header and entry sizes up to alignment
  always_comb begin
    lg = slab_size_log2;
    if (lg < 5'd12) lg = 5'd12;
    if (lg > 5'd16) lg = 5'd16;
    slab_bytes = 17'd1 << lg;
    align = 8'd1 << alignment_log2;
    hdr = 17'(HEADER_BYTES + LINK_BYTES) + 17'(align) - 17'd1;
    first = (hdr & ~(17'(align) - 17'd1)) - 17'(LINK_BYTES);
    esize = (17'(LINK_BYTES) + 17'(element_size) + 17'(align) - 17'd1)
            & ~(17'(align) - 17'd1);
  end

  assign trial = {rem, num[QW-1]} - {1'b0, esize};

  // Restoring division of (slab - first) by entry size
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= 5'(QW);
        rem  <= '0;
        num  <= (slab_bytes > first) ? slab_bytes - first : 17'd0;
        quo  <= '0;
      end else if (busy) begin
        if (!trial[17]) begin
          rem <= trial[16:0];
          quo <= {quo[15:0], 1'b1};
        end else begin
          rem <= {rem[15:0], num[QW-1]};
          quo <= {quo[15:0], 1'b0};
        end
        num <= {num[15:0], 1'b0};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cap = (quo > 17'(MAX_ENTRIES)) ? CapW'(MAX_ENTRIES) : CapW'(quo);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import slab_pkg::*;

  localparam logic [ModeW-1:0] MODE_NOP = 2'd3;
  localparam int NSLAB = MaxSlabsDef;
  localparam int NENT = MaxEntriesDef;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [3:0]       slab;
    logic [7:0]       entry;
    logic [15:0]      offset;
    logic [16:0]      reclaimed;
  } result_t;

  typedef struct packed {
    logic [3:0] slab;
    logic [7:0] entry;
  } handle_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDatW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = '0;
  logic [3:0] free_slab = '0;
  logic [7:0] free_entry = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [3:0] slab_index;
  logic [7:0] entry_index;
  logic [15:0] byte_offset;
  logic [16:0] reclaimed_bytes;

  slab_allocator_core u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .free_slab(free_slab),
    .free_entry(free_entry),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .slab_index(slab_index),
    .entry_index(entry_index), .byte_offset(byte_offset), .reclaimed_bytes(reclaimed_bytes)
  );

  always #10 clk = ~clk;

  // Allocator shadow state
  logic [4:0]  sh_slab_log2;
  logic [12:0] sh_elem_size;
  logic [2:0]  sh_align_log2;
  logic [8:0]  sh_link [NSLAB*NENT];
  logic [8:0]  sh_freed_top [NSLAB];
  logic [8:0]  sh_untouched [NSLAB];
  logic [8:0]  sh_used [NSLAB];
  logic [15:0] sh_color [NSLAB];
  logic [4:0]  sh_prev [NSLAB];
  logic [4:0]  sh_next [NSLAB];
  logic [4:0]  sh_head, sh_avail, sh_tail;
  logic [15:0] sh_next_color;
  logic [NSLAB-1:0] sh_frame_free;

  result_t pending_results[$];
  handle_t live_handles[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  int mismatches = 0;
  int idle_cycles = 0;
  int n_requests = 0, n_alloc_ok = 0, n_no_frame = 0, n_free_ok = 0;
  int n_idle_free = 0, n_reaped = 0, n_results = 0;

  function automatic int slab_bytes();
    int lg;
    lg = sh_slab_log2;
    if (lg < 12) lg = 12;
    if (lg > 16) lg = 16;
    return 1 << lg;
  endfunction

  function automatic void calc_geometry(output int first, output int esize, output int cap);
    int al, sz;
    al = 1 << sh_align_log2;
    first = ((HeaderBytesDef + LinkBytesDef + al - 1) & ~(al - 1)) - LinkBytesDef;
    esize = (LinkBytesDef + sh_elem_size + al - 1) & ~(al - 1);
    sz = slab_bytes();
    cap = (sz > first) ? (sz - first) / esize : 0;
    if (cap > NENT) cap = NENT;
  endfunction

  function automatic bit slab_full(int s);
    return sh_freed_top[s] == NENT && sh_untouched[s] == 0;
  endfunction

  function automatic void unlink_slab(int s);
    int p, n;
    p = sh_prev[s];
    n = sh_next[s];
    if (p < NSLAB) sh_next[p] = n;
    if (n < NSLAB) sh_prev[n] = p;
    sh_prev[s] = NSLAB;
    sh_next[s] = NSLAB;
  endfunction

  function automatic void link_after(int s, int p);
    int n;
    n = sh_next[p];
    sh_next[s] = n;
    if (n < NSLAB) sh_prev[n] = s;
    sh_prev[s] = p;
    sh_next[p] = s;
  endfunction

  function automatic void reset_shadow();
    sh_slab_log2 = 12;
    sh_elem_size = 32;
    sh_align_log2 = 3;
    foreach (sh_link[i]) sh_link[i] = '0;
    for (int i = 0; i < NSLAB; i++) begin
      sh_freed_top[i] = NENT;
      sh_untouched[i] = 0;
      sh_used[i] = 0;
      sh_color[i] = 0;
      sh_prev[i] = NSLAB;
      sh_next[i] = NSLAB;
    end
    sh_head = NSLAB;
    sh_avail = NSLAB;
    sh_tail = NSLAB;
    sh_next_color = 0;
    sh_frame_free = '1;
  endfunction

  function automatic result_t alloc_entry();
    result_t r;
    int first, es, cap, f, s, e, sz;
    longint nc;
    r = '0;
    sz = slab_bytes();
    if (sh_avail >= NSLAB) begin
      calc_geometry(first, es, cap);
      if (cap == 0) begin
        r.status = ST_NOFRAME;
        return r;
      end
      f = NSLAB;
      for (int i = NSLAB - 1; i >= 0; i--) if (sh_frame_free[i]) f = i;
      if (f >= NSLAB) begin
        r.status = ST_NOFRAME;
        return r;
      end
      sh_frame_free[f] = 1'b0;
      sh_freed_top[f] = NENT;
      sh_untouched[f] = cap;
      sh_used[f] = 0;
      sh_color[f] = sh_next_color;
      nc = sh_next_color + (1 << sh_align_log2);
      if (longint'(first) + nc + longint'(es) * cap > sz) nc = 0;
      sh_next_color = nc[15:0];
      sh_prev[f] = NSLAB;
      sh_next[f] = NSLAB;
      sh_avail = f;
      if (sh_tail < NSLAB) begin
        link_after(f, sh_tail);
        sh_tail = f;
      end else begin
        sh_head = f;
        sh_tail = f;
      end
    end
    s = sh_avail;
    if (sh_freed_top[s] < NENT) begin
      e = sh_freed_top[s];
      sh_freed_top[s] = sh_link[s*NENT + e];
    end else if (sh_untouched[s] > 0) begin
      sh_untouched[s] = sh_untouched[s] - 1;
      e = sh_untouched[s];
    end else begin
      r.status = ST_NOFRAME;
      return r;
    end
    sh_used[s] = sh_used[s] + 1;
    if (slab_full(s)) sh_avail = sh_next[s];
    calc_geometry(first, es, cap);
    r.status = ST_OK;
    r.slab = s[3:0];
    r.entry = e[7:0];
    r.offset = 16'(first + sh_color[s] + e * es + LinkBytesDef);
    return r;
  endfunction

  function automatic result_t free_entry_slot(int s, int e);
    result_t r;
    bit prior_full;
    int n, p;
    r = '0;
    if (e >= NENT || sh_frame_free[s] || sh_used[s] == 0) begin
      r.status = ST_IDLEFREE;
      return r;
    end
    prior_full = slab_full(s);
    sh_link[s*NENT + e] = sh_freed_top[s];
    sh_freed_top[s] = e;
    sh_used[s] = sh_used[s] - 1;
    if (prior_full) begin
      n = sh_next[s];
      if (n < NSLAB && slab_full(n)) begin
        if (s == sh_head) sh_head = n;
        unlink_slab(s);
        if (sh_avail < NSLAB) begin
          p = sh_prev[sh_avail];
          if (p < NSLAB) link_after(s, p);
          else begin
            sh_next[s] = sh_avail;
            sh_prev[sh_avail] = s;
            sh_head = s;
          end
        end else if (sh_tail < NSLAB) begin
          link_after(s, sh_tail);
          sh_tail = s;
        end else begin
          sh_head = s;
          sh_tail = s;
        end
      end
      sh_avail = s;
    end else if (sh_used[s] == 0) begin
      n = sh_next[s];
      if (n < NSLAB && sh_used[n] != 0) begin
        if (s == sh_head) sh_head = n;
        if (s == sh_avail) sh_avail = n;
        unlink_slab(s);
        link_after(s, sh_tail);
        sh_tail = s;
      end
    end
    return r;
  endfunction

  function automatic result_t reap_tail();
    result_t r;
    int s;
    r = '0;
    s = sh_tail;
    if (sh_head >= NSLAB || s >= NSLAB || s == sh_head || sh_used[s] != 0) begin
      r.status = ST_NOREAP;
      return r;
    end
    if (sh_avail == s) sh_avail = NSLAB;
    sh_tail = sh_prev[s];
    unlink_slab(s);
    sh_freed_top[s] = NENT;
    sh_untouched[s] = 0;
    sh_color[s] = 0;
    sh_frame_free[s] = 1'b1;
    r.reclaimed = 17'(slab_bytes());
    return r;
  endfunction

  // Predict one transaction and record its outcome
  function automatic result_t predict_request(logic [1:0] m, logic [3:0] s, logic [7:0] e);
    result_t r;
    r = '0;
    case (m)
      MODE_ALLOC: begin
        r = alloc_entry();
        if (r.status == ST_OK) begin
          n_alloc_ok++;
          live_handles.push_back({r.slab, r.entry});
        end else n_no_frame++;
      end
      MODE_FREE: begin
        r = free_entry_slot(s, e);
        if (r.status == ST_OK) n_free_ok++;
        else n_idle_free++;
      end
      MODE_REAP: begin
        r = reap_tail();
        if (r.status == ST_OK) n_reaped++;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic send_request(input logic [1:0] m, input logic [3:0] s, input logic [7:0] e);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    free_slab <= s;
    free_entry <= e;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_request(m, s, e));
    n_requests++;
  endtask

  // Drop valid and wait for every outstanding result plus pipeline slack
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input int value);
    drain_block();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CfgDatW'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SLAB_LOG2:  sh_slab_log2 = 5'(value);
      REG_ELEM_SIZE:  sh_elem_size = 13'(value);
      REG_ALIGN_LOG2: sh_align_log2 = 3'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input int lg, input int esz, input int al);
    write_register(REG_SLAB_LOG2, lg);
    write_register(REG_ELEM_SIZE, esz);
    write_register(REG_ALIGN_LOG2, al);
  endtask

  // Free a random live entry, dropping its handle unless keep is set
  task automatic free_live_entry(input bit keep);
    int k;
    handle_t h;
    k = $urandom_range(live_handles.size() - 1);
    h = live_handles[k];
    if (!keep) live_handles.delete(k);
    send_request(MODE_FREE, h.slab, h.entry);
  endtask

  task automatic test_reset_defaults();
    send_request(MODE_REAP, 4'd0, 8'd0);
    send_request(MODE_FREE, 4'd15, 8'd255);
    send_request(MODE_FREE, 4'd0, 8'd0);
    send_request(MODE_NOP, 4'd9, 8'd170);
    repeat (4) send_request(MODE_ALLOC, 4'd0, 8'd0);
    send_request(MODE_FREE, 4'd0, 8'd99);
    send_request(MODE_FREE, 4'd0, 8'd99);
    send_request(MODE_ALLOC, 4'd0, 8'd0);
    send_request(MODE_ALLOC, 4'd0, 8'd0);
    send_request(MODE_FREE, 4'd15, 8'd0);
    send_request(MODE_REAP, 4'd0, 8'd0);
    live_handles.delete();
    drain_block();
  endtask

  task automatic test_geometry_extremes();
    // zero capacity: element larger than the slab body
    set_geometry(12, 4096, 0);
    send_request(MODE_ALLOC, 4'd0, 8'd0);
    // saturated slab sizes at both ends
    set_geometry(0, 1, 7);
    repeat (3) send_request(MODE_ALLOC, 4'd0, 8'd0);
    set_geometry(31, 4096, 7);
    repeat (3) send_request(MODE_ALLOC, 4'd0, 8'd0);
    set_geometry(16, 1, 0);
    repeat (3) send_request(MODE_ALLOC, 4'd0, 8'd0);
    // tiny slabs with many frames: fill until no frame is left
    set_geometry(12, 2000, 2);
    repeat (36) send_request(MODE_ALLOC, 4'd0, 8'd0);
    while (live_handles.size() != 0) free_live_entry(1'b0);
    repeat (17) send_request(MODE_REAP, 4'd0, 8'd0);
    drain_block();
  endtask

  task automatic test_backpressure();
    set_geometry(13, 100, 4);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    repeat (30) send_request(MODE_ALLOC, 4'd0, 8'd0);
    repeat (10) free_live_entry(1'b0);
    drain_block();
  endtask

  task automatic random_traffic(input int count, input int idle_pct, input int stall_pct);
    int pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (live_handles.size() > 60 && pick < 50) pick = 60;
      if (pick < 48) send_request(MODE_ALLOC, 4'($urandom), 8'($urandom));
      else if (pick < 82 && live_handles.size() != 0) free_live_entry(1'b0);
      else if (pick < 84 && live_handles.size() != 0) free_live_entry(1'b1);
      else if (pick < 91) send_request(MODE_FREE, 4'($urandom), 8'($urandom));
      else if (pick < 98) send_request(MODE_REAP, 4'($urandom), 8'($urandom));
      else send_request(MODE_NOP, 4'($urandom), 8'($urandom));
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_block();
  endtask

  task automatic test_random_traffic();
    set_geometry(12, 500, 3);
    random_traffic(225, 0, 0);
    set_geometry(12, 1200, 7);
    random_traffic(225, 73, 0);
    set_geometry(14, 3000, 1);
    random_traffic(225, 0, 73);
    // register change with slabs still populated
    write_register(REG_ELEM_SIZE, 700);
    random_traffic(225, 21, 21);
  endtask

  // Drive output stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (rst) out_stall <= 1'b0;
    else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each result against the oldest prediction
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result, status %0d", status);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r != {status, slab_index, entry_index, byte_offset, reclaimed_bytes}) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d exp st=%0d slab=%0d ent=%0d off=%0d rec=%0d",
                     n_results, exp_r.status, exp_r.slab, exp_r.entry, exp_r.offset,
                     exp_r.reclaimed);
            $display("       got st=%0d slab=%0d ent=%0d off=%0d rec=%0d",
                     status, slab_index, entry_index, byte_offset, reclaimed_bytes);
          end
        end
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: watchdog expired");
      $display("slab_allocator_core test failed");
      $finish;
    end
  end

  initial begin
    reset_shadow();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_geometry_extremes();
    test_backpressure();
    test_random_traffic();
    drain_block();
    $display("Covered %0d requests: %0d allocations, %0d no-frame, %0d frees, %0d idle frees,",
             n_requests, n_alloc_ok, n_no_frame, n_free_ok, n_idle_free);
    $display("  %0d reaps, %0d results checked, %0d mismatches", n_reaped, n_results,
             mismatches);
    if (mismatches == 0) $display("slab_allocator_core test passed");
    else $display("slab_allocator_core test failed");
    $finish;
  end

endmodule
